// File: sv/bcrf_pkg.sv
// bcrf_pkg: shared types and constants of the border connected region fill block
// request and result structs, controller/datapath command and status structs, codes
// no dependencies
package bcrf_pkg;

  localparam int DEFAULT_MAX_ROWS = 64;
  localparam int DEFAULT_MAX_COLS = 64;
  localparam int CFG_ROWS_RST     = 64;
  localparam int CFG_COLS_RST     = 64;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // cell codes held in the grid store
  localparam logic [1:0] CELL_CLOSED = 2'd0;
  localparam logic [1:0] CELL_OPEN   = 2'd1;
  localparam logic [1:0] CELL_MARKED = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] row;
    logic [5:0] col;
    logic       cell_in;
  } req_t;

  typedef struct packed {
    logic       cell_out;
    logic [1:0] op_done;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // take request: latch op, write cell or issue cell read
    logic rd_cap;     // capture read cell into result
    logic cur_first;  // cursor to row 0, column 0
    logic brd_next;   // cursor to next border cell
    logic swp_next;   // cursor to next cell in raster order
    logic visit;      // mark cursor cell and push it if it reads open
    logic sweep;      // rewrite cursor cell: open to closed, marked to open
    logic pop;        // read frontier at head
    logic base_ld;    // popped cell becomes neighbor base
    logic rd_nb;      // read current neighbor, cursor follows
    logic nb_next;    // step to next neighbor
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic q_empty;
    logic nb_ok;
    logic nb_last;
    logic brd_last;
    logic swp_last;
  } sts_t;

endpackage

// File: sv/bcrf_ram.sv
// bcrf_ram: generic single write port, single read port ram with registered read
// depends on nothing
module bcrf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/bcrf_dp.sv
// bcrf_dp: datapath of the region fill: grid store, frontier queue, cursors, result
// depends on bcrf_pkg and bcrf_ram
module bcrf_dp import bcrf_pkg::*; #(
  parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
  parameter int MAX_COLS = DEFAULT_MAX_COLS,
  localparam int RNW = $clog2(MAX_ROWS + 1),
  localparam int CNW = $clog2(MAX_COLS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cmd_t           cmd_i,
  output sts_t           sts_o,
  input  req_t           req_i,
  input  logic [RNW-1:0] rows_i,
  input  logic [CNW-1:0] cols_i,
  output res_t           res_o
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RXW = RW + 1;
  localparam int CXW = CW + 1;
  localparam int AW  = RW + CW;
  localparam int QD  = MAX_ROWS * MAX_COLS;
  localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);

  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_DOWN  = 2'd1;
  localparam logic [1:0] NB_LEFT  = 2'd2;
  localparam logic [1:0] NB_RIGHT = 2'd3;

  logic [1:0]     op_q;
  logic           inside_q, cell_q;
  logic [RW-1:0]  cur_r_q, base_r_q;
  logic [CW-1:0]  cur_c_q, base_c_q;
  logic [1:0]     k_q;
  logic [QCW-1:0] head_q, tail_q;

  logic [RW-1:0]  req_r, nb_r;
  logic [CW-1:0]  req_c, nb_c;
  logic           req_inside, nb_ok;
  logic [RXW-1:0] rows_x, cur_r_inc, base_r_inc;
  logic [CXW-1:0] cols_x, cur_c_inc, base_c_inc;
  logic           border_row, c_step, mid_jump, last_row;

  logic [AW-1:0]  g_raddr, g_waddr;
  logic [1:0]     g_wdata, g_rdata;
  logic           g_we, q_we;
  logic [AW-1:0]  q_rdata;

  assign req_r      = RW'(req_i.row);
  assign req_c      = CW'(req_i.col);
  assign req_inside = (int'(req_i.row) < MAX_ROWS) && (int'(req_i.col) < MAX_COLS);

  assign rows_x     = RXW'(rows_i);
  assign cols_x     = CXW'(cols_i);
  assign cur_r_inc  = RXW'(cur_r_q) + RXW'(1);
  assign cur_c_inc  = CXW'(cur_c_q) + CXW'(1);
  assign base_r_inc = RXW'(base_r_q) + RXW'(1);
  assign base_c_inc = CXW'(base_c_q) + CXW'(1);

  assign last_row   = (cur_r_inc == rows_x);
  assign border_row = (cur_r_q == '0) || last_row;
  assign c_step     = (cur_c_inc < cols_x);
  // inner rows only hold the first and the last column
  assign mid_jump   = (cur_c_q == '0) && (cols_x > CXW'(1));

  always_comb begin
    nb_ok = 1'b0;
    nb_r  = base_r_q;
    nb_c  = base_c_q;
    case (k_q)
      NB_UP: begin
        nb_ok = (base_r_q != '0);
        nb_r  = base_r_q - RW'(1);
      end
      NB_DOWN: begin
        nb_ok = (base_r_inc < rows_x);
        nb_r  = base_r_inc[RW-1:0];
      end
      NB_LEFT: begin
        nb_ok = (base_c_q != '0);
        nb_c  = base_c_q - CW'(1);
      end
      NB_RIGHT: begin
        nb_ok = (base_c_inc < cols_x);
        nb_c  = base_c_inc[CW-1:0];
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign sts_o.q_empty  = (head_q == tail_q);
  assign sts_o.nb_ok    = nb_ok;
  assign sts_o.nb_last  = (k_q == NB_RIGHT);
  assign sts_o.brd_last = (border_row ? !c_step : !mid_jump) && last_row;
  assign sts_o.swp_last = !c_step && last_row;

  always_comb begin
    if (cmd_i.accept) begin
      g_raddr = {req_r, req_c};
    end else if (cmd_i.rd_nb) begin
      g_raddr = {nb_r, nb_c};
    end else begin
      g_raddr = {cur_r_q, cur_c_q};
    end
  end

  always_comb begin
    g_we    = 1'b0;
    g_waddr = {cur_r_q, cur_c_q};
    g_wdata = CELL_MARKED;
    if (cmd_i.accept) begin
      g_we    = (req_i.op == OP_WRITE) && req_inside;
      g_waddr = {req_r, req_c};
      g_wdata = {1'b0, req_i.cell_in};
    end else if (cmd_i.visit) begin
      g_we    = (g_rdata == CELL_OPEN);
    end else if (cmd_i.sweep) begin
      case (g_rdata)
        CELL_OPEN: begin
          g_we    = 1'b1;
          g_wdata = CELL_CLOSED;
        end
        CELL_MARKED: begin
          g_we    = 1'b1;
          g_wdata = CELL_OPEN;
        end
        default: begin
          g_we    = 1'b0;
        end
      endcase
    end
  end

  assign q_we = cmd_i.visit && (g_rdata == CELL_OPEN);

  bcrf_ram #(
    .WIDTH (2),
    .DEPTH (2 ** AW)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  bcrf_ram #(
    .WIDTH (AW),
    .DEPTH (QD)
  ) u_frontier (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail_q[QAW-1:0]),
    .wdata_i ({cur_r_q, cur_c_q}),
    .raddr_i (head_q[QAW-1:0]),
    .rdata_o (q_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      k_q    <= NB_UP;
    end else begin
      if (cmd_i.accept) begin
        head_q <= '0;
        tail_q <= '0;
      end else begin
        if (cmd_i.pop) begin
          head_q <= head_q + QCW'(1);
        end
        if (q_we) begin
          tail_q <= tail_q + QCW'(1);
        end
      end
      if (cmd_i.base_ld) begin
        k_q <= NB_UP;
      end else if (cmd_i.nb_next) begin
        k_q <= k_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= req_i.op;
      inside_q <= req_inside;
      cell_q   <= 1'b0;
    end else if (cmd_i.rd_cap) begin
      cell_q   <= inside_q && (g_rdata == CELL_OPEN);
    end

    if (cmd_i.cur_first) begin
      cur_r_q <= '0;
      cur_c_q <= '0;
    end else if (cmd_i.brd_next) begin
      if (border_row ? c_step : mid_jump) begin
        cur_c_q <= border_row ? cur_c_inc[CW-1:0] : CW'(cols_i - CNW'(1));
      end else begin
        cur_r_q <= cur_r_inc[RW-1:0];
        cur_c_q <= '0;
      end
    end else if (cmd_i.swp_next) begin
      if (c_step) begin
        cur_c_q <= cur_c_inc[CW-1:0];
      end else begin
        cur_r_q <= cur_r_inc[RW-1:0];
        cur_c_q <= '0;
      end
    end else if (cmd_i.rd_nb) begin
      cur_r_q <= nb_r;
      cur_c_q <= nb_c;
    end

    if (cmd_i.base_ld) begin
      base_r_q <= q_rdata[AW-1:CW];
      base_c_q <= q_rdata[CW-1:0];
    end
  end

  assign res_o.cell_out = cell_q;
  assign res_o.op_done  = op_q;

endmodule

// File: sv/bcrf_ctrl.sv
// bcrf_ctrl: sequencer of the region fill: request handling, border seeding,
// frontier drain and final sweep; depends on bcrf_pkg
module bcrf_ctrl import bcrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] op_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_RDW     = 11'b000_0000_0010,
    S_BRD_RD  = 11'b000_0000_0100,
    S_BRD_CHK = 11'b000_0000_1000,
    S_QTEST   = 11'b000_0001_0000,
    S_Q_LD    = 11'b000_0010_0000,
    S_NB_RD   = 11'b000_0100_0000,
    S_NB_CHK  = 11'b000_1000_0000,
    S_SW_RD   = 11'b001_0000_0000,
    S_SW_WR   = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = !((state_q == S_IDLE) || (state_q == S_DONE));
  assign done_o = (state_q == S_DONE);
  assign accept = start_i && !busy_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE, S_DONE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          case (op_i)
            OP_READ: begin
              state_d = S_RDW;
            end
            OP_RUN: begin
              cmd_o.cur_first = 1'b1;
              state_d         = S_BRD_RD;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RDW: begin
        cmd_o.rd_cap = 1'b1;
        state_d      = S_DONE;
      end
      S_BRD_RD: begin
        state_d = S_BRD_CHK;
      end
      S_BRD_CHK: begin
        cmd_o.visit = 1'b1;
        if (sts_i.brd_last) begin
          state_d = S_QTEST;
        end else begin
          cmd_o.brd_next = 1'b1;
          state_d        = S_BRD_RD;
        end
      end
      S_QTEST: begin
        if (sts_i.q_empty) begin
          cmd_o.cur_first = 1'b1;
          state_d         = S_SW_RD;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_Q_LD;
        end
      end
      S_Q_LD: begin
        cmd_o.base_ld = 1'b1;
        state_d       = S_NB_RD;
      end
      S_NB_RD: begin
        if (sts_i.nb_ok) begin
          cmd_o.rd_nb = 1'b1;
          state_d     = S_NB_CHK;
        end else if (sts_i.nb_last) begin
          state_d = S_QTEST;
        end else begin
          cmd_o.nb_next = 1'b1;
        end
      end
      S_NB_CHK: begin
        cmd_o.visit = 1'b1;
        if (sts_i.nb_last) begin
          state_d = S_QTEST;
        end else begin
          cmd_o.nb_next = 1'b1;
          state_d       = S_NB_RD;
        end
      end
      S_SW_RD: begin
        state_d = S_SW_WR;
      end
      S_SW_WR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.swp_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.swp_next = 1'b1;
          state_d        = S_SW_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/border_connected_region_fill.sv
// border_connected_region_fill: top level, apb register file and sequencer/datapath
// depends on bcrf_pkg, bcrf_ctrl, bcrf_dp, bcrf_ram
//
// usage: a request (op, row, col, cell_in) is taken at a rising edge with start high and
// busy low. every request gives one result on res_o, shown for exactly one cycle with
// done_o high; the receiver cannot stall, so nothing is held back.
// per request: a write or unknown op goes straight to the result, a read takes one
// registered grid store read. a run visits the B border cells (2*C + 2*(R-2) when
// the R rows and C columns are both at least 2), then pops each of the V cells
// reached from the border and reads its in-grid neighbors (Q in all), then sweeps
// all R*C cells; every grid read goes through the single read port of the grid store.
// busy drops in the result cycle, so the next request is taken while the result shows.
// grid_rows and grid_cols sit at paddr 0 and 4 (paddr[2] selects), are clamped to
// 1..MAX on write and should only be written while the block is idle.
// reset: registers go to 64 x 64 (clamped to the maxima), the sequencer to idle; grid
// contents are undefined until written and get no clearing pass.
module border_connected_region_fill import bcrf_pkg::*; #(
  parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
  parameter int MAX_COLS = DEFAULT_MAX_COLS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output res_t        res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RNW     = $clog2(MAX_ROWS + 1);
  localparam int CNW     = $clog2(MAX_COLS + 1);
  localparam int RowsRst = (CFG_ROWS_RST > MAX_ROWS) ? MAX_ROWS : CFG_ROWS_RST;
  localparam int ColsRst = (CFG_COLS_RST > MAX_COLS) ? MAX_COLS : CFG_COLS_RST;

  logic [RNW-1:0] rows_q, rows_d;
  logic [CNW-1:0] cols_q, cols_d;
  logic [6:0]     wval;
  logic           cfg_we;
  cmd_t           cmd;
  sts_t           sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign wval   = pwdata[6:0];

  // only pwdata[6:0] is used: zero counts as one, anything above the maximum as the maximum
  always_comb begin
    if (wval == '0) begin
      rows_d = RNW'(1);
      cols_d = CNW'(1);
    end else begin
      rows_d = (int'(wval) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(wval);
      cols_d = (int'(wval) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(wval);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RNW'(RowsRst);
      cols_q <= CNW'(ColsRst);
    end else if (cfg_we) begin
      if (paddr[2] == REG_COLS) begin
        cols_q <= cols_d;
      end else begin
        rows_q <= rows_d;
      end
    end
  end

  assign prdata = (paddr[2] == REG_ROWS) ? 32'(rows_q) : 32'(cols_q);

  bcrf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (req_i.op),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  bcrf_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req_i  (req_i),
    .rows_i (rows_q),
    .cols_i (cols_q),
    .res_o  (res_o)
  );

endmodule
